// ===== rtl/mat_pkg.sv =====
// Shared constants, codes and types of the multi-ant grid block.
`default_nettype none

package mat_pkg;

    // Table and grid sizes
    localparam int MAX_ANTS  = 8;
    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int ANT_W     = $clog2(MAX_ANTS);
    localparam int CNT_W     = $clog2(MAX_ANTS + 1);
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int DIM_W     = $clog2(MAX_ROWS + 1);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int CELL_W    = 1;
    localparam int HD_W      = 2;
    localparam int OP_W      = 2;

    // Bus widths
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Register reset values
    localparam logic [DIM_W-1:0] ROWS_RST = DIM_W'(256);
    localparam logic [DIM_W-1:0] COLS_RST = DIM_W'(256);
    localparam logic [CNT_W-1:0] ANTS_RST = CNT_W'(1);

    // Register indexes (word address paddr[3:2])
    typedef enum logic [1:0] {
        REG_ROWS = 2'd0,
        REG_COLS = 2'd1,
        REG_ANTS = 2'd2
    } t_reg_idx;

    // Operation codes carried in tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_READ = 2'd2
    } t_op;

    // Headings
    localparam logic [HD_W-1:0] HD_UP    = 2'd0;
    localparam logic [HD_W-1:0] HD_RIGHT = 2'd1;
    localparam logic [HD_W-1:0] HD_DOWN  = 2'd2;
    localparam logic [HD_W-1:0] HD_LEFT  = 2'd3;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [CNT_W-1:0] ants;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/mat_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none

module mat_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mat_cfg.sv =====
// APB register file for grid size and ant count, with clamped outputs.
`default_nettype none

module mat_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mat_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mat_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mat_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output mat_pkg::t_cfg                      o_cfg
);

    logic [mat_pkg::DIM_W-1:0] r_rows;
    logic [mat_pkg::DIM_W-1:0] r_cols;
    logic [mat_pkg::CNT_W-1:0] r_ants;
    mat_pkg::t_reg_idx         reg_idx;
    logic                      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = mat_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;

    // Write the addressed register; keep the raw value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= mat_pkg::ROWS_RST;
            r_cols <= mat_pkg::COLS_RST;
            r_ants <= mat_pkg::ANTS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                mat_pkg::REG_ROWS: r_rows <= pwdata[mat_pkg::DIM_W-1:0];
                mat_pkg::REG_COLS: r_cols <= pwdata[mat_pkg::DIM_W-1:0];
                mat_pkg::REG_ANTS: r_ants <= pwdata[mat_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the raw register
    always_comb begin
        case (reg_idx)
            mat_pkg::REG_ROWS: prdata = mat_pkg::PDATA_W'(r_rows);
            mat_pkg::REG_COLS: prdata = mat_pkg::PDATA_W'(r_cols);
            mat_pkg::REG_ANTS: prdata = mat_pkg::PDATA_W'(r_ants);
            default:           prdata = '0;
        endcase
    end

    // Saturate to the legal ranges
    always_comb begin
        if (r_rows == '0) begin
            o_cfg.rows = mat_pkg::DIM_W'(1);
        end else if (r_rows > mat_pkg::DIM_W'(mat_pkg::MAX_ROWS)) begin
            o_cfg.rows = mat_pkg::DIM_W'(mat_pkg::MAX_ROWS);
        end else begin
            o_cfg.rows = r_rows;
        end
        if (r_cols == '0) begin
            o_cfg.cols = mat_pkg::DIM_W'(1);
        end else if (r_cols > mat_pkg::DIM_W'(mat_pkg::MAX_COLS)) begin
            o_cfg.cols = mat_pkg::DIM_W'(mat_pkg::MAX_COLS);
        end else begin
            o_cfg.cols = r_cols;
        end
        if (r_ants == '0) begin
            o_cfg.ants = mat_pkg::CNT_W'(1);
        end else if (r_ants > mat_pkg::CNT_W'(mat_pkg::MAX_ANTS)) begin
            o_cfg.ants = mat_pkg::CNT_W'(mat_pkg::MAX_ANTS);
        end else begin
            o_cfg.ants = r_ants;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mat_move.sv =====
// Shared turn-and-move unit: new heading and wrapped position of one ant.
`default_nettype none

module mat_move (
    input  wire logic [mat_pkg::ROW_W-1:0] i_row,
    input  wire logic [mat_pkg::COL_W-1:0] i_col,
    input  wire logic [mat_pkg::HD_W-1:0]  i_hd,
    input  wire logic                      i_seen,
    input  wire logic [mat_pkg::DIM_W-1:0] i_rows,
    input  wire logic [mat_pkg::DIM_W-1:0] i_cols,
    output logic      [mat_pkg::ROW_W-1:0] o_row,
    output logic      [mat_pkg::COL_W-1:0] o_col,
    output logic      [mat_pkg::HD_W-1:0]  o_hd
);

    logic [mat_pkg::HD_W-1:0]  hd_new;
    logic [mat_pkg::DIM_W-1:0] row_t;
    logic [mat_pkg::DIM_W-1:0] col_t;
    logic [mat_pkg::DIM_W-1:0] row_x;
    logic [mat_pkg::DIM_W-1:0] col_x;

    // Turn left on a set cell, right on a clear one
    assign hd_new = i_seen ? (i_hd + mat_pkg::HD_W'(3)) : (i_hd + mat_pkg::HD_W'(1));
    assign o_hd   = hd_new;
    assign row_x  = mat_pkg::DIM_W'(i_row);
    assign col_x  = mat_pkg::DIM_W'(i_col);

    // Step one cell; below zero wraps to the last line
    always_comb begin
        row_t = row_x;
        col_t = col_x;
        case (hd_new)
            mat_pkg::HD_UP: begin
                row_t = (row_x == '0) ? (i_rows - mat_pkg::DIM_W'(1))
                                      : (row_x - mat_pkg::DIM_W'(1));
            end
            mat_pkg::HD_DOWN:  row_t = row_x + mat_pkg::DIM_W'(1);
            mat_pkg::HD_LEFT: begin
                col_t = (col_x == '0) ? (i_cols - mat_pkg::DIM_W'(1))
                                      : (col_x - mat_pkg::DIM_W'(1));
            end
            mat_pkg::HD_RIGHT: col_t = col_x + mat_pkg::DIM_W'(1);
            default: ;
        endcase
    end

    // At or beyond the edge wraps to zero
    assign o_row = (row_t >= i_rows) ? '0 : row_t[mat_pkg::ROW_W-1:0];
    assign o_col = (col_t >= i_cols) ? '0 : col_t[mat_pkg::COL_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/multi_ant_turmite_grid_top.sv =====
// Top level of the multi-ant turmite grid: sequencer, ant table and grid memory.
//
// Multi-ant turmite on a toroidal grid of one-bit cells held in a single-port
// 65536 x 1 memory. After reset the block runs a clearing pass over the grid, one
// cell a cycle, and accepts no transaction until it ends; register writes are
// taken throughout. A load or a cell read makes one grid memory read before its
// result is offered. A step of n ants first reads and flips each ant's cell in
// turn through the one memory port, then passes each ant through the shared
// turn-and-move unit and hands over its result, waiting out any output stall.
// One transaction is processed at a time; s_axis_tready is high only while the
// block is idle.
`default_nettype none

module multi_ant_turmite_grid_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mat_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [mat_pkg::PDATA_W-1:0]     pwdata,
    output logic      [mat_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready,
    // Input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // ant_index[2:0], row[10:3], col[18:11], heading[20:19], zero[23:21]
    input  wire logic [mat_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // op[1:0]
    input  wire logic [mat_pkg::OP_W-1:0]        s_axis_tuser,
    // Output stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // which_ant[2:0], new_row[10:3], new_col[18:11], new_heading[20:19],
    // cell_value[21], zero[23:22]
    output logic      [mat_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                                 m_axis_tlast,
    // status[0]
    output logic                                 m_axis_tuser
);

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_CELL_RD  = 7'b0000100,
        ST_CELL_OUT = 7'b0001000,
        ST_STEP_RD  = 7'b0010000,
        ST_STEP_WR  = 7'b0100000,
        ST_STEP_MV  = 7'b1000000
    } t_state;

    t_state                     r_state;
    logic                       r_step_out;
    logic [mat_pkg::ADDR_W-1:0] r_clr;
    logic [mat_pkg::ANT_W-1:0]  r_ant;
    logic [mat_pkg::ROW_W-1:0]  r_ant_row [mat_pkg::MAX_ANTS];
    logic [mat_pkg::COL_W-1:0]  r_ant_col [mat_pkg::MAX_ANTS];
    logic [mat_pkg::HD_W-1:0]   r_ant_hd  [mat_pkg::MAX_ANTS];
    logic [mat_pkg::MAX_ANTS-1:0] r_seen;
    logic                       r_rd_ok;

    logic                       r_out_valid;
    logic [mat_pkg::ANT_W-1:0]  r_out_ant;
    logic [mat_pkg::ROW_W-1:0]  r_out_row;
    logic [mat_pkg::COL_W-1:0]  r_out_col;
    logic [mat_pkg::HD_W-1:0]   r_out_hd;
    logic                       r_out_cell;
    logic                       r_out_st;
    logic                       r_out_last;

    mat_pkg::t_cfg              cfg;
    mat_pkg::t_op               in_op;
    logic [mat_pkg::ANT_W-1:0]  in_idx;
    logic [mat_pkg::ROW_W-1:0]  in_row;
    logic [mat_pkg::COL_W-1:0]  in_col;
    logic [mat_pkg::HD_W-1:0]   in_hd;
    logic                       in_acc;
    logic                       out_hs;
    logic                       oob;

    logic [mat_pkg::ROW_W-1:0]  cur_row;
    logic [mat_pkg::COL_W-1:0]  cur_col;
    logic [mat_pkg::HD_W-1:0]   cur_hd;
    logic [mat_pkg::ADDR_W-1:0] cur_addr;
    logic                       dup;
    logic                       last_ant;
    logic [mat_pkg::ROW_W-1:0]  mv_row;
    logic [mat_pkg::COL_W-1:0]  mv_col;
    logic [mat_pkg::HD_W-1:0]   mv_hd;

    logic                       ram_we;
    logic [mat_pkg::ADDR_W-1:0] ram_addr;
    logic [mat_pkg::CELL_W-1:0] ram_wdata;
    logic [mat_pkg::CELL_W-1:0] ram_rdata;

    // Configuration registers
    mat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Unpack the input transaction
    assign in_op  = mat_pkg::t_op'(s_axis_tuser);
    assign in_idx = s_axis_tdata[2:0];
    assign in_row = s_axis_tdata[10:3];
    assign in_col = s_axis_tdata[18:11];
    assign in_hd  = s_axis_tdata[20:19];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_hs        = r_out_valid & m_axis_tready;

    // Position outside the grid in use
    assign oob = (mat_pkg::DIM_W'(in_row) >= cfg.rows) ||
                 (mat_pkg::DIM_W'(in_col) >= cfg.cols);

    // Ant under service
    assign cur_row  = r_ant_row[r_ant];
    assign cur_col  = r_ant_col[r_ant];
    assign cur_hd   = r_ant_hd[r_ant];
    assign cur_addr = {cur_row, cur_col};
    assign last_ant = ((mat_pkg::CNT_W'(r_ant) + mat_pkg::CNT_W'(1)) == cfg.ants);

    // Detect an earlier ant on the same cell: that cell is already flipped
    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < mat_pkg::MAX_ANTS; j++) begin
            if ((mat_pkg::ANT_W'(j) < r_ant) &&
                ({r_ant_row[j], r_ant_col[j]} == cur_addr)) begin
                dup = 1'b1;
            end
        end
    end

    // Shared turn-and-move unit
    mat_move u_move (
        .i_row  (cur_row),
        .i_col  (cur_col),
        .i_hd   (cur_hd),
        .i_seen (r_seen[r_ant]),
        .i_rows (cfg.rows),
        .i_cols (cfg.cols),
        .o_row  (mv_row),
        .o_col  (mv_col),
        .o_hd   (mv_hd)
    );

    // Grid memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = {in_row, in_col};
        ram_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr;
            end
            ST_STEP_RD: ram_addr = cur_addr;
            ST_STEP_WR: begin
                ram_addr  = cur_addr;
                ram_we    = ~dup;
                ram_wdata = ~ram_rdata;
            end
            default: ;
        endcase
    end

    mat_ram #(
        .WIDTH (mat_pkg::CELL_W),
        .DEPTH (mat_pkg::CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Sequencer and ant table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_step_out  <= 1'b0;
            r_clr       <= '0;
            r_ant       <= '0;
            r_out_valid <= 1'b0;
            r_seen      <= '0;
            for (int k = 0; k < mat_pkg::MAX_ANTS; k++) begin
                r_ant_row[k] <= '0;
                r_ant_col[k] <= '0;
                r_ant_hd[k]  <= mat_pkg::HD_UP;
            end
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + mat_pkg::ADDR_W'(1);
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        case (in_op)
                            mat_pkg::OP_LOAD: begin
                                if (!oob) begin
                                    r_ant_row[in_idx] <= in_row;
                                    r_ant_col[in_idx] <= in_col;
                                    r_ant_hd[in_idx]  <= in_hd;
                                end
                                r_state <= ST_CELL_RD;
                            end
                            mat_pkg::OP_READ: r_state <= ST_CELL_RD;
                            mat_pkg::OP_STEP: begin
                                r_ant   <= '0;
                                r_state <= ST_STEP_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CELL_RD: begin
                    r_out_valid <= 1'b1;
                    r_step_out  <= 1'b0;
                    r_state     <= ST_CELL_OUT;
                end
                ST_CELL_OUT: begin
                    // Hold until the result transaction completes
                    if (out_hs) begin
                        r_out_valid <= 1'b0;
                        if (!r_step_out || r_out_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_ant   <= r_ant + mat_pkg::ANT_W'(1);
                            r_state <= ST_STEP_MV;
                        end
                    end
                end
                ST_STEP_RD: r_state <= ST_STEP_WR;
                ST_STEP_WR: begin
                    r_seen[r_ant] <= ram_rdata[0] ^ dup;
                    if (last_ant) begin
                        r_ant   <= '0;
                        r_state <= ST_STEP_MV;
                    end else begin
                        r_ant   <= r_ant + mat_pkg::ANT_W'(1);
                        r_state <= ST_STEP_RD;
                    end
                end
                ST_STEP_MV: begin
                    r_ant_row[r_ant] <= mv_row;
                    r_ant_col[r_ant] <= mv_col;
                    r_ant_hd[r_ant]  <= mv_hd;
                    r_out_valid      <= 1'b1;
                    r_step_out       <= 1'b1;
                    r_state          <= ST_CELL_OUT;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && in_acc) begin
            r_out_ant  <= (in_op == mat_pkg::OP_LOAD) ? in_idx : '0;
            r_out_row  <= in_row;
            r_out_col  <= in_col;
            r_out_hd   <= (in_op == mat_pkg::OP_LOAD) ? in_hd : mat_pkg::HD_UP;
            r_out_st   <= (in_op == mat_pkg::OP_LOAD) && oob;
            r_out_last <= 1'b1;
            r_rd_ok    <= ~oob;
        end else if (r_state == ST_CELL_RD) begin
            r_out_cell <= ram_rdata[0] & r_rd_ok;
        end else if (r_state == ST_STEP_MV) begin
            r_out_ant  <= r_ant;
            r_out_row  <= mv_row;
            r_out_col  <= mv_col;
            r_out_hd   <= mv_hd;
            r_out_cell <= ~r_seen[r_ant];
            r_out_st   <= 1'b0;
            r_out_last <= last_ant;
        end
    end

    // Pack the result transaction
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_cell, r_out_hd, r_out_col, r_out_row, r_out_ant};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_st;

endmodule

`default_nettype wire

// ===== rtl/mat_chk.sv =====
// Port-level checker for the multi-ant grid block, bound to the top level.
`default_nettype none

module mat_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [mat_pkg::OP_W-1:0]      s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [mat_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                          m_axis_tlast,
    input wire logic                          m_axis_tuser
);

    // Never take a new transaction while a result is on offer
    a_busy_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    // A valid operation keeps the block busy in the following cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser == mat_pkg::OP_LOAD || s_axis_tuser == mat_pkg::OP_STEP ||
          s_axis_tuser == mat_pkg::OP_READ)) |=> !s_axis_tready)
        else $error("input ready right after an operation");

    // A rejected load is a single final result with a zero cell
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && !m_axis_tdata[21]))
        else $error("rejected load result malformed");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind multi_ant_turmite_grid_top mat_chk u_mat_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
